/* design/descriptor_table_lowest_free_unit_defines.svh */
// Assertion macros for the descriptor table block.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef DESCRIPTOR_TABLE_LOWEST_FREE_UNIT_DEFINES_SVH
`define DESCRIPTOR_TABLE_LOWEST_FREE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define DTLF_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
`define DTLF_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`define DTLF_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define DTLF_ASSERT_ALWAYS(lbl, cond, msg)
`define DTLF_ASSERT_IMPL(lbl, ante, cons, msg)
`define DTLF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/dtlf_pkg.sv */
// Shared types and constants for the descriptor table block.
// No dependencies.
package dtlf_pkg;

   localparam int FUNC_W          = 3;
   localparam int SLOT_W          = 9;
   localparam int HANDLE_W        = 32;
   localparam int STATUS_W        = 2;
   localparam int SLOT_OUT_W      = 8;
   localparam int CMP_W           = SLOT_W + 1;
   localparam int GROUP_W         = 16;
   localparam int GROUP_IDX_W     = 4;
   localparam int MAX_ENTRIES_DEF = 256;
   localparam int HANDLE_BITS_DEF = 32;
   localparam int INITIAL_SIZE    = 32;
   localparam int GROW_STEP       = 8;

   typedef enum logic [FUNC_W-1:0] {
      FN_GET      = 3'd0,
      FN_ADD      = 3'd1,
      FN_REMOVE   = 3'd2,
      FN_DUP      = 3'd3,
      FN_TEST     = 3'd4,
      FN_SET_FLAG = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_BAD_SLOT = 2'd1,
      ST_INVALID  = 2'd2,
      ST_TOO_MANY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_REFRESH
   } state_type;

   typedef struct packed {
      logic             load;
      logic [CMP_W-1:0] start;
      logic [CMP_W-1:0] limit;
   } srch_req_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] idx;
   } srch_rsp_type;

endpackage

/* design/dtlf_ifs.sv */
// Request and response channel interfaces of the descriptor table block.
// Depends on dtlf_pkg.
interface dtlf_req_if;
   import dtlf_pkg::*;

   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [SLOT_W-1:0]   slot;
   logic [SLOT_W-1:0]   target_slot;
   logic                target_any;
   logic                exact;
   logic [HANDLE_W-1:0] handle;
   logic                flag;

   modport source (output valid, func, slot, target_slot, target_any, exact, handle, flag,
                   input ready);
   modport sink (input valid, func, slot, target_slot, target_any, exact, handle, flag,
                 output ready);
endinterface

interface dtlf_rsp_if;
   import dtlf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [STATUS_W-1:0]   status;
   logic [SLOT_OUT_W-1:0] slot_out;
   logic [HANDLE_W-1:0]   handle_out;
   logic                  released_valid;
   logic [HANDLE_W-1:0]   released_handle;
   logic                  flag_out;

   modport source (output valid, status, slot_out, handle_out, released_valid,
                   released_handle, flag_out, input ready);
   modport sink (input valid, status, slot_out, handle_out, released_valid,
                 released_handle, flag_out, output ready);
endinterface

/* design/dtlf_store.sv */
// Slot store: handle plus close-on-exec bit per slot, one write and one read port.
// Read data registered. Depends on dtlf_pkg.
module dtlf_store #(
   parameter int MAX_ENTRIES = dtlf_pkg::MAX_ENTRIES_DEF,
   parameter int HANDLE_BITS = dtlf_pkg::HANDLE_BITS_DEF
) (
   input  logic                           clock,
   input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
   output logic [HANDLE_BITS:0]           rd_data,
   input  logic                           wr_en,
   input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
   input  logic [HANDLE_BITS:0]           wr_data
);
   import dtlf_pkg::*;

   logic [HANDLE_BITS:0] store_ff [MAX_ENTRIES];
   logic [HANDLE_BITS:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/dtlf_search.sv */
// Two-stage lowest-free-slot encoder over the occupancy bits.
// Groups encoded and registered on load, group pick combinational after. Depends on dtlf_pkg.
module dtlf_search #(
   parameter int MAX_ENTRIES = dtlf_pkg::MAX_ENTRIES_DEF
) (
   input  logic                   clock,
   input  dtlf_pkg::srch_req_type srch_req,
   input  logic [MAX_ENTRIES-1:0] occupied,
   output dtlf_pkg::srch_rsp_type srch_rsp
);
   import dtlf_pkg::*;

   localparam int NGRP  = (MAX_ENTRIES + GROUP_W - 1) / GROUP_W;
   localparam int PAD_W = NGRP * GROUP_W;
   localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;

   logic [PAD_W-1:0]       occ_pad;
   logic [PAD_W-1:0]       cand;
   logic [NGRP-1:0]        any_in;
   logic [GROUP_IDX_W-1:0] off_in [NGRP];
   logic [NGRP-1:0]        any_ff;
   logic [GROUP_IDX_W-1:0] off_ff [NGRP];
   logic [GRP_W-1:0]       grp;
   logic [GRP_W+GROUP_IDX_W-1:0] idx_full;

   assign occ_pad = PAD_W'(occupied);

   always_comb begin
      for (int i = 0; i < PAD_W; i++) begin
         cand[i] = !occ_pad[i] && (CMP_W'(i) >= srch_req.start) &&
                   (CMP_W'(i) < srch_req.limit);
      end
   end

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         any_in[g] = |cand[g*GROUP_W +: GROUP_W];
         off_in[g] = '0;
         for (int j = GROUP_W - 1; j >= 0; j--) begin
            if (cand[g*GROUP_W + j]) begin
               off_in[g] = GROUP_IDX_W'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (srch_req.load) begin
         any_ff <= any_in;
         off_ff <= off_in;
      end
   end

   always_comb begin
      grp = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (any_ff[g]) begin
            grp = GRP_W'(g);
         end
      end
      idx_full       = {grp, off_ff[grp]};
      srch_rsp.found = |any_ff;
      srch_rsp.idx   = SLOT_W'(idx_full);
   end

endmodule

/* design/descriptor_table_lowest_free_unit.sv */
// Channel | dir | handshake           | word
// req     | in  | req.valid/req.ready | func, slot, target_slot, target_any, exact, handle, flag
// rsp     | out | rsp.valid/rsp.ready | status, slot_out, handle_out, released_*, flag_out
// Each op: accept (source read issued, upward search loaded), read, execute (store
// write, result registered), then the free-slot refresh through the two-stage
// encoder. A waiting result holds the execute step and no new word is taken until
// idle again. Reset clears occupancy and lowest free slot and sets logical size to INITIAL_SIZE;
// store contents are not cleared. Depends on dtlf_pkg, dtlf_ifs, dtlf_store, dtlf_search.
`include "descriptor_table_lowest_free_unit_defines.svh"
module descriptor_table_lowest_free_unit #(
   parameter int MAX_ENTRIES = dtlf_pkg::MAX_ENTRIES_DEF,
   parameter int HANDLE_BITS = dtlf_pkg::HANDLE_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   dtlf_req_if.sink   req,
   dtlf_rsp_if.source rsp
);
   import dtlf_pkg::*;

   localparam int IDX_W  = $clog2(MAX_ENTRIES);
   localparam int SIZE_W = $clog2(MAX_ENTRIES + 1);
   localparam int ENT_W  = HANDLE_BITS + 1;

   state_type state_ff, state_in;

   logic [FUNC_W-1:0]   func_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   tgt_ff;
   logic                any_ff;
   logic                exact_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic                flag_ff;
   logic [ENT_W-1:0]    src_data_ff;
   logic                found_ff;
   logic [IDX_W-1:0]    found_idx_ff;

   logic [MAX_ENTRIES-1:0] occ_ff, occ_in;
   logic [SIZE_W-1:0]      size_ff, size_in;
   logic [SIZE_W-1:0]      lowest_free_ff, lowest_free_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            status_ff, status_in;
   logic [SLOT_OUT_W-1:0] slot_out_ff, slot_out_in;
   logic [HANDLE_W-1:0]   handle_out_ff, handle_out_in;
   logic                  rel_valid_ff, rel_valid_in;
   logic [HANDLE_W-1:0]   rel_handle_ff, rel_handle_in;
   logic                  flag_out_ff, flag_out_in;

   logic              accept;
   logic              exec_fire;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_data;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [ENT_W-1:0]  mem_wdata;
   srch_req_type      srch_req;
   srch_rsp_type      srch_rsp;

   logic                         src_ok;
   logic                         low_avail;
   logic [CMP_W-1:0]             grown;
   logic                         take_ok;
   logic [SIZE_W-1:0]            take_slot;
   logic [IDX_W-1:0]             dest;
   logic [CMP_W-1:0]             dest_plus;
   logic                         do_write;
   logic                         set_occ;
   logic                         clr_occ;
   logic [SIZE_W-1:0]            size_op;
   logic [ENT_W-1:0]             wdata_op;
   logic [HANDLE_W+HANDLE_BITS-1:0] h_wide;
   logic [HANDLE_BITS-1:0]       h_store;
   logic [HANDLE_BITS+HANDLE_W-1:0] src_wide;
   logic [HANDLE_BITS+HANDLE_W-1:0] dst_wide;
   logic [HANDLE_BITS+HANDLE_W-1:0] new_wide;
   logic [HANDLE_W-1:0]          src_h_out;
   logic [HANDLE_W-1:0]          dst_h_out;
   logic [HANDLE_W-1:0]          new_h_out;

   assign accept    = req.valid && req.ready;
   assign exec_fire = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp.ready);
   assign req.ready = (state_ff == S_IDLE);

   assign rd_addr = (state_ff == S_IDLE) ? req.slot[IDX_W-1:0] : tgt_ff[IDX_W-1:0];

   dtlf_store #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_store (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata)
   );

   // upward search on accept, refresh of the lowest free slot on execute
   always_comb begin
      srch_req.load  = accept || exec_fire;
      srch_req.start = (state_ff == S_IDLE) ? CMP_W'(req.target_slot) : '0;
      srch_req.limit = (state_ff == S_IDLE) ? CMP_W'(MAX_ENTRIES) : CMP_W'(size_in);
   end

   dtlf_search #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_search (
      .clock    (clock),
      .srch_req (srch_req),
      .occupied (occ_in),
      .srch_rsp (srch_rsp)
   );

   always_comb begin
      h_wide    = {{HANDLE_BITS{1'b0}}, handle_ff};
      h_store   = h_wide[HANDLE_BITS-1:0];
      src_wide  = {{HANDLE_W{1'b0}}, src_data_ff[HANDLE_BITS-1:0]};
      dst_wide  = {{HANDLE_W{1'b0}}, rd_data[HANDLE_BITS-1:0]};
      new_wide  = {{HANDLE_W{1'b0}}, h_store};
      src_h_out = src_wide[HANDLE_W-1:0];
      dst_h_out = dst_wide[HANDLE_W-1:0];
      new_h_out = new_wide[HANDLE_W-1:0];
   end

   // execute: one op against the captured source entry
   always_comb begin
      src_ok    = (CMP_W'(slot_ff) < CMP_W'(size_ff)) && occ_ff[slot_ff[IDX_W-1:0]];
      low_avail = lowest_free_ff < size_ff;
      grown     = CMP_W'(size_ff) + CMP_W'(GROW_STEP);
      take_ok   = low_avail || (grown <= CMP_W'(MAX_ENTRIES));
      take_slot = low_avail ? lowest_free_ff : size_ff;

      status_in     = ST_OK;
      slot_out_in   = '0;
      handle_out_in = '0;
      rel_valid_in  = 1'b0;
      rel_handle_in = '0;
      flag_out_in   = 1'b0;
      dest          = slot_ff[IDX_W-1:0];
      dest_plus     = '0;
      do_write      = 1'b0;
      set_occ       = 1'b0;
      clr_occ       = 1'b0;
      size_op       = size_ff;
      wdata_op      = {1'b0, src_data_ff[HANDLE_BITS-1:0]};

      case (func_ff)
         FN_GET: begin
            if (!src_ok) begin
               status_in = ST_BAD_SLOT;
            end else begin
               handle_out_in = src_h_out;
            end
         end
         FN_ADD: begin
            if (!take_ok) begin
               status_in = ST_TOO_MANY;
            end else begin
               dest          = take_slot[IDX_W-1:0];
               size_op       = low_avail ? size_ff : grown[SIZE_W-1:0];
               wdata_op      = {1'b0, h_store};
               do_write      = 1'b1;
               set_occ       = 1'b1;
               slot_out_in   = SLOT_OUT_W'(dest);
               handle_out_in = new_h_out;
            end
         end
         FN_REMOVE: begin
            if (!src_ok) begin
               status_in = ST_BAD_SLOT;
            end else begin
               rel_valid_in  = 1'b1;
               rel_handle_in = src_h_out;
               clr_occ       = 1'b1;
            end
         end
         FN_DUP: begin
            if (!src_ok) begin
               status_in = ST_BAD_SLOT;
            end else if (!any_ff && (CMP_W'(tgt_ff) >= CMP_W'(MAX_ENTRIES))) begin
               status_in = ST_INVALID;
            end else if (any_ff) begin
               if (!take_ok) begin
                  status_in = ST_TOO_MANY;
               end else begin
                  dest     = take_slot[IDX_W-1:0];
                  size_op  = low_avail ? size_ff : grown[SIZE_W-1:0];
                  do_write = 1'b1;
               end
            end else if (exact_ff) begin
               dest      = tgt_ff[IDX_W-1:0];
               dest_plus = CMP_W'(dest) + CMP_W'(1);
               if (CMP_W'(dest) >= CMP_W'(size_ff)) begin
                  size_op = dest_plus[SIZE_W-1:0];
               end
               do_write = 1'b1;
               if (occ_ff[dest]) begin
                  rel_valid_in  = 1'b1;
                  rel_handle_in = dst_h_out;
               end
            end else begin
               if (!found_ff) begin
                  status_in = ST_TOO_MANY;
               end else begin
                  dest      = found_idx_ff;
                  dest_plus = CMP_W'(dest) + CMP_W'(1);
                  if (CMP_W'(dest) >= CMP_W'(size_ff)) begin
                     size_op = dest_plus[SIZE_W-1:0];
                  end
                  do_write = 1'b1;
               end
            end
            if (do_write) begin
               set_occ       = 1'b1;
               slot_out_in   = SLOT_OUT_W'(dest);
               handle_out_in = src_h_out;
            end
         end
         FN_TEST: begin
            if (!src_ok) begin
               status_in = ST_BAD_SLOT;
            end else begin
               flag_out_in = src_data_ff[HANDLE_BITS];
            end
         end
         FN_SET_FLAG: begin
            if (!src_ok) begin
               status_in = ST_BAD_SLOT;
            end else begin
               wdata_op = {flag_ff, src_data_ff[HANDLE_BITS-1:0]};
               do_write = 1'b1;
            end
         end
         default: begin
            status_in = ST_INVALID;
         end
      endcase

      mem_we    = exec_fire && do_write;
      mem_waddr = dest;
      mem_wdata = wdata_op;

      occ_in  = occ_ff;
      size_in = size_ff;
      if (exec_fire) begin
         size_in = size_op;
         if (set_occ) begin
            occ_in[dest] = 1'b1;
         end
         if (clr_occ) begin
            occ_in[dest] = 1'b0;
         end
      end

      lowest_free_in = lowest_free_ff;
      if (state_ff == S_REFRESH) begin
         lowest_free_in = srch_rsp.found ? SIZE_W'(srch_rsp.idx) : size_ff;
      end

      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp.ready;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (exec_fire) begin
               state_in = S_REFRESH;
            end
         end
         S_REFRESH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         occ_ff         <= '0;
         size_ff        <= SIZE_W'(INITIAL_SIZE);
         lowest_free_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         occ_ff         <= occ_in;
         size_ff        <= size_in;
         lowest_free_ff <= lowest_free_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff   <= req.func;
         slot_ff   <= req.slot;
         tgt_ff    <= req.target_slot;
         any_ff    <= req.target_any;
         exact_ff  <= req.exact;
         handle_ff <= req.handle;
         flag_ff   <= req.flag;
      end
      if (state_ff == S_READ) begin
         src_data_ff  <= rd_data;
         found_ff     <= srch_rsp.found;
         found_idx_ff <= srch_rsp.idx[IDX_W-1:0];
      end
      if (exec_fire) begin
         status_ff     <= status_in;
         slot_out_ff   <= slot_out_in;
         handle_out_ff <= handle_out_in;
         rel_valid_ff  <= rel_valid_in;
         rel_handle_ff <= rel_handle_in;
         flag_out_ff   <= flag_out_in;
      end
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = status_ff;
   assign rsp.slot_out        = slot_out_ff;
   assign rsp.handle_out      = handle_out_ff;
   assign rsp.released_valid  = rel_valid_ff;
   assign rsp.released_handle = rel_handle_ff;
   assign rsp.flag_out        = flag_out_ff;

   `DTLF_ASSERT_ALWAYS(a_lowest_in_size, lowest_free_ff <= size_ff, "lowest free past size")
   `DTLF_ASSERT_IMPL(a_lowest_is_free, (state_ff == S_IDLE) && (lowest_free_ff < size_ff), !occ_ff[lowest_free_ff[IDX_W-1:0]], "lowest free slot is occupied")
   `DTLF_ASSERT_IMPL(a_size_grows_only, !$past(reset), size_ff >= $past(size_ff), "logical size shrank")
   `DTLF_ASSERT_NEXT(a_write_occupies, mem_we, occ_ff[$past(mem_waddr)], "written slot not occupied")

endmodule
